[hw/rtl/keypad_decimal_calculator_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for keypad_decimal_calculator
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_DECIMAL_CALCULATOR_ASSERT_SVH
`define KEYPAD_DECIMAL_CALCULATOR_ASSERT_SVH

// Same-cycle implication.
`define KDC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define KDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/kdc_pkg.sv]
// ----------------------------------------------------------------------------
// kdc_pkg
// Types, codes and BCD helpers for the keypad decimal calculator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kdc_pkg;

  localparam int unsigned DIGITS = 4;   // entry width in decimal digits, 1..8
  localparam int unsigned SHOWN  = 4;   // digits on the display ports

  typedef logic [DIGITS-1:0][3:0] bcd_t;

  localparam bcd_t BCD_MAX = {DIGITS{4'd9}};

  typedef enum logic [2:0] {
    KEY_DIGIT  = 3'd0,
    KEY_ADD    = 3'd1,
    KEY_SUB    = 3'd2,
    KEY_EQUALS = 3'd3,
    KEY_BACK   = 3'd4,
    KEY_NEG    = 3'd5
  } key_e;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_ADD  = 2'd1,
    OP_SUB  = 2'd2
  } pend_op_e;

  localparam logic [3:0] DIGIT_MAX = 4'd9;

  typedef struct packed {
    logic carry;
    bcd_t mag;
  } bcd_res_t;

  // Ripple BCD add, carry out of the top digit means the sum exceeds BCD_MAX.
  function automatic bcd_res_t bcd_add(input bcd_t a, input bcd_t b);
    logic       c;
    logic [4:0] s;
    bcd_res_t   r;
    c = 1'b0;
    r = '0;
    for (int k = 0; k < DIGITS; k++) begin
      s = {1'b0, a[k]} + {1'b0, b[k]} + {4'b0, c};
      if (s > 5'd9) begin
        r.mag[k] = 4'(s - 5'd10);
        c        = 1'b1;
      end else begin
        r.mag[k] = s[3:0];
        c        = 1'b0;
      end
    end
    r.carry = c;
    return r;
  endfunction

  // Ripple BCD subtract, caller guarantees a >= b.
  function automatic bcd_t bcd_sub(input bcd_t a, input bcd_t b);
    logic       bw;
    logic [4:0] d;
    bcd_t       r;
    bw = 1'b0;
    r  = '0;
    for (int k = 0; k < DIGITS; k++) begin
      d = {1'b0, a[k]} - {1'b0, b[k]} - {4'b0, bw};
      if (d[4]) begin
        r[k] = 4'(d + 5'd10);
        bw   = 1'b1;
      end else begin
        r[k] = d[3:0];
        bw   = 1'b0;
      end
    end
    return r;
  endfunction

endpackage

[hw/rtl/keypad_decimal_calculator.sv]
// ----------------------------------------------------------------------------
// keypad_decimal_calculator
// Four-digit decimal calculator driven by key words, saturating at 9999.
//
//   channel  direction  fields                                      handshake
//   in       input      op_i, digit_i                               in_valid_i / in_ready_o
//   out      output     shown_*_o, minus_shown_o, overflow_o        out_valid_o / out_ready_i
//
// One key word per cycle while out_ready_i is high; its result word is valid the cycle after acceptance.
// All arithmetic is done in BCD sign-magnitude in a single pass, so no binary
// conversion sits in the path; the ripple over the entry digits sets its depth.
// The calculator state doubles as the output register: in_ready_o is high
// whenever no result is waiting or the waiting one is taken in this cycle.
// Reset (rst_ni low) clears the entry, operand, pending operation and flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "keypad_decimal_calculator_assert.svh"

module keypad_decimal_calculator (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] op_i,
  input  logic [3:0] digit_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] shown_ones_o,
  output logic [3:0] shown_tens_o,
  output logic [3:0] shown_hundreds_o,
  output logic [3:0] shown_thousands_o,
  output logic       minus_shown_o,
  output logic       overflow_o
);
  import kdc_pkg::*;

  bcd_t     entry_q, entry_d;
  bcd_t     first_mag_q, first_mag_d;
  logic     first_neg_q, first_neg_d;
  pend_op_e pend_q, pend_d;
  logic     neg_q, neg_d;
  logic     minus_q, minus_d;
  logic     ovf_q, ovf_d;
  logic     out_valid_q;
  logic     acc;

  bcd_res_t sum;
  bcd_t     diff_fs;
  bcd_t     diff_sf;
  logic     second_neg;
  logic     first_ge;
  bcd_t     res_mag;
  logic     res_neg;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign acc        = in_valid_i && in_ready_o;

  assign second_neg = neg_q ^ (pend_q == OP_SUB);
  assign sum        = bcd_add(first_mag_q, entry_q);
  assign diff_fs    = bcd_sub(first_mag_q, entry_q);
  assign diff_sf    = bcd_sub(entry_q, first_mag_q);
  assign first_ge   = first_mag_q >= entry_q;

  always_comb begin
    if (first_neg_q == second_neg) begin
      res_mag = sum.carry ? BCD_MAX : sum.mag;
      res_neg = first_neg_q;
    end else if (first_ge) begin
      res_mag = diff_fs;
      res_neg = first_neg_q;
    end else begin
      res_mag = diff_sf;
      res_neg = second_neg;
    end
  end

  always_comb begin
    entry_d     = entry_q;
    first_mag_d = first_mag_q;
    first_neg_d = first_neg_q;
    pend_d      = pend_q;
    neg_d       = neg_q;
    minus_d     = minus_q;
    ovf_d       = ovf_q;
    case (key_e'(op_i))
      KEY_DIGIT: begin
        if (digit_i <= DIGIT_MAX) begin
          for (int k = DIGITS - 1; k > 0; k--) begin
            entry_d[k] = entry_q[k-1];
          end
          entry_d[0] = digit_i;
        end
      end
      KEY_ADD, KEY_SUB: begin
        pend_d      = (key_e'(op_i) == KEY_ADD) ? OP_ADD : OP_SUB;
        first_mag_d = entry_q;
        first_neg_d = neg_q;
        neg_d       = 1'b0;
        entry_d     = '0;
        minus_d     = 1'b0;
      end
      KEY_EQUALS: begin
        neg_d   = 1'b0;
        minus_d = 1'b0;
        if (pend_q == OP_ADD || pend_q == OP_SUB) begin
          entry_d = res_mag;
          minus_d = res_neg && (res_mag != '0);
          ovf_d   = (first_neg_q == second_neg) && sum.carry;
        end
      end
      KEY_BACK: begin
        for (int k = 0; k < DIGITS - 1; k++) begin
          entry_d[k] = entry_q[k+1];
        end
        entry_d[DIGITS-1] = '0;
      end
      KEY_NEG: begin
        neg_d   = 1'b1;
        minus_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q     <= '0;
      first_mag_q <= '0;
      first_neg_q <= 1'b0;
      pend_q      <= OP_NONE;
      neg_q       <= 1'b0;
      minus_q     <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        entry_q     <= entry_d;
        first_mag_q <= first_mag_d;
        first_neg_q <= first_neg_d;
        pend_q      <= pend_d;
        neg_q       <= neg_d;
        minus_q     <= minus_d;
        ovf_q       <= ovf_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  logic [SHOWN-1:0][3:0] shown;

  for (genvar k = 0; k < SHOWN; k++) begin : g_shown
    if (k < DIGITS) begin : g_digit
      assign shown[k] = entry_q[k];
    end else begin : g_blank
      assign shown[k] = '0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign shown_ones_o      = shown[0];
  assign shown_tens_o      = shown[1];
  assign shown_hundreds_o  = shown[2];
  assign shown_thousands_o = shown[3];
  assign minus_shown_o     = minus_q;
  assign overflow_o        = ovf_q;

  `KDC_ASSERT_NEXT(a_op_clears_entry,
    acc && (op_i == KEY_ADD || op_i == KEY_SUB),
    entry_q == '0 && !minus_q,
    "add/sub did not clear the entry")
  `KDC_ASSERT_NEXT(a_digit_shifts_in,
    acc && op_i == KEY_DIGIT && digit_i <= DIGIT_MAX,
    shown_ones_o == $past(digit_i),
    "digit key not shifted into the entry")
  `KDC_ASSERT_NEXT(a_unused_key_holds,
    acc && op_i > KEY_NEG,
    $stable(entry_q) && $stable(first_mag_q) && $stable(pend_q) && $stable(neg_q),
    "unused key changed the state")
  `KDC_ASSERT_NEXT(a_equals_no_op,
    acc && op_i == KEY_EQUALS && pend_q == OP_NONE,
    $stable(entry_q) && $stable(ovf_q) && !minus_q && !neg_q,
    "equals without operation changed the result")

endmodule
